[design/thread_pointer_offset_scanner_top_macros.svh]
// Assertion macros shared by the scanner's checker.
`ifndef THREAD_POINTER_OFFSET_SCANNER_TOP_MACROS_SVH
`define THREAD_POINTER_OFFSET_SCANNER_TOP_MACROS_SVH

// Property checked on the rising clock edge, switched off while reset is held.
`define TPOS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tpos assertion failed");

// Property checked on the rising clock edge, reset cycles included.
`define TPOS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tpos assertion failed");

`endif

[design/tpos_pkg.sv]
// Package with the scanner's instruction patterns, phase codes and result type.
package tpos_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned REG_W  = 5;
  localparam int unsigned IMM_W  = 12;

  localparam logic [WORD_W-1:0] STP_MASK  = 32'hFFC0_7FFF;
  localparam logic [WORD_W-1:0] STP_MATCH = 32'hA980_7BFD;
  localparam logic [WORD_W-1:0] MOV_MASK  = 32'hFFE0_FFFF;
  localparam logic [WORD_W-1:0] MOV_MATCH = 32'h9100_03FD;
  localparam logic [WORD_W-1:0] MRS_MASK  = 32'hFFFF_FFE0;
  localparam logic [WORD_W-1:0] MRS_MATCH = 32'hD53B_D040;
  localparam logic [WORD_W-1:0] LDR_BASE  = 32'hF940_0000;
  localparam logic [WORD_W-1:0] ADD_MASK  = 32'hFF80_03FF;
  localparam logic [WORD_W-1:0] ADD_BASE  = 32'h9100_0000;

  localparam int unsigned ADD_SHIFT_BIT = 22;
  localparam int unsigned ADD_IMM_LSB   = 10;

  typedef enum logic [4:0] {
    PH_FIRST = 5'b00001,
    PH_MOV   = 5'b00010,
    PH_MRS   = 5'b00100,
    PH_SCAN  = 5'b01000,
    PH_WAIT  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] offset;
  } result_t;

  typedef struct packed {
    logic              last;
    logic [WORD_W-1:0] word;
  } item_t;

endpackage

[design/tpos_in_stage.sv]
// Input register stage: captures one instruction word per accepted transaction.
module tpos_in_stage
  import tpos_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [WORD_W-1:0] in_insn_word,
  input  logic              in_last_word,
  output logic              in_stall,
  input  logic              advance,
  output logic              item_valid,
  output item_t             item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall   = valid_r && !advance;
  assign accept     = in_valid && !in_stall;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.word <= in_insn_word;
      item_r.last <= in_last_word;
    end
  end

endmodule

[design/tpos_matcher.sv]
// Pattern matcher: phase, base register and running offset, stepped once per word.
module tpos_matcher
  import tpos_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output logic    emit,
  output result_t result
);

  phase_t            phase_r, phase_nxt;
  logic [REG_W-1:0]  base_r, base_nxt;
  logic [WORD_W-1:0] offset_r, offset_nxt;

  logic [WORD_W-1:0] w;
  logic [WORD_W-1:0] ldr_word;
  logic [WORD_W-1:0] add_word;
  logic [WORD_W-1:0] imm;
  logic              ended;

  assign w        = item.word;
  assign ldr_word = LDR_BASE | {{(WORD_W-2*REG_W){1'b0}}, base_r, {REG_W{1'b0}}};
  assign add_word = ADD_BASE | {{(WORD_W-2*REG_W){1'b0}}, base_r, base_r};

  always_comb begin
    if (w[ADD_SHIFT_BIT]) begin
      imm = {{(WORD_W-2*IMM_W){1'b0}}, w[ADD_IMM_LSB +: IMM_W], {IMM_W{1'b0}}};
    end else begin
      imm = {{(WORD_W-IMM_W){1'b0}}, w[ADD_IMM_LSB +: IMM_W]};
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    base_nxt   = base_r;
    offset_nxt = offset_r;
    emit       = 1'b0;
    result     = '0;
    ended      = 1'b0;
    unique case (phase_r)
      PH_FIRST: begin
        if ((w & STP_MASK) == STP_MATCH) begin
          phase_nxt = PH_MOV;
        end else if ((w & MRS_MASK) == MRS_MATCH) begin
          base_nxt   = w[REG_W-1:0];
          offset_nxt = '0;
          phase_nxt  = PH_SCAN;
        end else begin
          emit  = 1'b1;
          ended = 1'b1;
        end
      end
      PH_MOV: begin
        if ((w & MOV_MASK) == MOV_MATCH) begin
          phase_nxt = PH_MRS;
        end else begin
          emit  = 1'b1;
          ended = 1'b1;
        end
      end
      PH_MRS: begin
        if ((w & MRS_MASK) == MRS_MATCH) begin
          base_nxt   = w[REG_W-1:0];
          offset_nxt = '0;
          phase_nxt  = PH_SCAN;
        end else begin
          emit  = 1'b1;
          ended = 1'b1;
        end
      end
      PH_SCAN: begin
        if (w == ldr_word) begin
          emit          = 1'b1;
          result.found  = 1'b1;
          result.offset = offset_r;
          ended         = 1'b1;
        end else if ((w & ADD_MASK) == add_word) begin
          offset_nxt = offset_r + imm;
        end else begin
          emit  = 1'b1;
          ended = 1'b1;
        end
      end
      default: begin
        // Result for this sequence is already out; idle until the last word.
        ended = 1'b1;
      end
    endcase

    if (ended) begin
      phase_nxt = PH_WAIT;
    end

    if (item.last) begin
      if (!ended) begin
        emit = 1'b1;
      end
      phase_nxt  = PH_FIRST;
      base_nxt   = '0;
      offset_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      base_r   <= '0;
      offset_r <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      base_r   <= base_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

[design/tpos_out_stage.sv]
// Result register stage: holds one result until the receiver takes it.
module tpos_out_stage
  import tpos_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  result_t           result,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_found,
  output logic [WORD_W-1:0] out_offset,
  output logic              room
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign room       = !valid_r || !out_stall;
  assign out_valid  = valid_r;
  assign out_found  = result_r.found;
  assign out_offset = result_r.offset;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

[design/thread_pointer_offset_scanner_top.sv]
// Thread pointer offset scanner: input register, pattern matcher, result register.
//
// Input channel (in_valid, in_stall, in_insn_word, in_last_word): one AArch64
// instruction word per transaction, in_last_word set on the final word.
// Output channel (out_valid, out_stall, out_found, out_offset): one result per
// sequence. out_offset is the summed add immediate when out_found is set, else 0.
// A result is given on the first mismatching word, on the matching load, or on
// the last word if neither came earlier; later words of that sequence give none.
// Words go through the input register, the matcher, then the result register.
// Throughput is one word per cycle when out_stall is low: the matcher decodes a
// word and updates its phase, base register and offset between the two registers.
// When the receiver stalls, the result register holds, the input register keeps
// its word, and in_stall rises once that register is occupied.
// Reset (rst_n low, synchronous) empties both registers and puts the matcher back
// to expecting the first word of a sequence.
module thread_pointer_offset_scanner_top
  import tpos_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] in_insn_word,
  input  logic              in_last_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic signed [WORD_W-1:0] out_offset
);

  logic              item_valid;
  item_t             item;
  logic              room;
  logic              advance;
  logic              emit;
  result_t           result;
  logic [WORD_W-1:0] offset_bits;

  assign advance    = item_valid && room;
  assign out_offset = $signed(offset_bits);

  tpos_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_insn_word(in_insn_word),
    .in_last_word(in_last_word),
    .in_stall    (in_stall),
    .advance     (advance),
    .item_valid  (item_valid),
    .item        (item)
  );

  tpos_matcher u_match (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item),
    .emit  (emit),
    .result(result)
  );

  tpos_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && emit),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_found (out_found),
    .out_offset(offset_bits),
    .room      (room)
  );

endmodule

[design/tpos_checker.sv]
// Port-level checker for the scanner, bound to the top level.
`include "thread_pointer_offset_scanner_top_macros.svh"

module tpos_checker
  import tpos_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_found,
  input logic [WORD_W-1:0] out_offset
);

  // A result that is not a match always reports a zero offset.
  `TPOS_ASSERT(a_miss_zero, out_valid && !out_found |-> out_offset == '0)
  // A new result appears only after a word was taken into the input register.
  `TPOS_ASSERT(a_result_has_word, $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
  // A stalled result stays offered.
  `TPOS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  // Reset empties the result register.
  `TPOS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind thread_pointer_offset_scanner_top tpos_checker u_tpos_checker (.*);
